// ===== rtl/core/bnf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_pkg
// shared widths and types for the batch-norm folding pipeline
// ----------------------------------------------------------------------------
package bnf_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int EPS_BITS     = 16;
    localparam int VAR_BITS     = WORD_BITS - 1;
    localparam int SUM_BITS     = WORD_BITS;
    localparam int RAD_BITS     = SUM_BITS + FRAC_BITS;
    localparam int SQ_STEPS     = (RAD_BITS + 1) / 2;
    localparam int RAD_PAD      = 2 * SQ_STEPS;
    localparam int ROOT_BITS    = SQ_STEPS;
    localparam int SQ_REM_BITS  = ROOT_BITS + 3;
    localparam int MAG_BITS     = WORD_BITS;
    localparam int NUM_BITS     = MAG_BITS + FRAC_BITS;
    localparam int QUO_BITS     = NUM_BITS;
    localparam int DIV_REM_BITS = ROOT_BITS + 1;
    localparam int PROD_BITS    = 2 * MAG_BITS;
    localparam int TDATA_IN     = ((3 * WORD_BITS + VAR_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT    = 2 * WORD_BITS;

    localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

    typedef struct packed {
        logic                        scale_neg;
        logic [MAG_BITS-1:0]         smag;
        logic [WORD_BITS-1:0]        bias;
        logic                        mean_neg;
        logic [MAG_BITS-1:0]         mmag;
        logic                        invalid;
    } t_side;

endpackage

// ===== rtl/core/bnf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module bnf_sqrt import bnf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [RAD_PAD-1:0]   i_rad,
    input  t_side                i_side,
    output logic                 o_vld,
    output logic [ROOT_BITS-1:0] o_root,
    output t_side                o_side
);

    logic                   r_vld  [SQ_STEPS];
    logic [SQ_REM_BITS-1:0] r_rem  [SQ_STEPS];
    logic [ROOT_BITS-1:0]   r_root [SQ_STEPS];
    logic [RAD_PAD-1:0]     r_rad  [SQ_STEPS];
    t_side                  r_side [SQ_STEPS];

    genvar g;
    for (g = 0; g < SQ_STEPS; g++) begin : g_stage
        logic                   p_vld;
        logic [SQ_REM_BITS-1:0] p_rem;
        logic [ROOT_BITS-1:0]   p_root;
        logic [RAD_PAD-1:0]     p_rad;
        t_side                  p_side;
        logic [SQ_REM_BITS-1:0] w_rem;
        logic [SQ_REM_BITS-1:0] w_trial;
        logic [SQ_REM_BITS-1:0] n_rem;
        logic [ROOT_BITS-1:0]   n_root;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_side = r_side[g-1];
        end

        assign w_rem   = {p_rem[SQ_REM_BITS-3:0], p_rad[2*(SQ_STEPS-1-g)+1 -: 2]};
        assign w_trial = {1'b0, p_root, 2'b01};

        always_comb begin
            if (w_rem >= w_trial) begin
                n_rem  = w_rem - w_trial;
                n_root = {p_root[ROOT_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_rem;
                n_root = {p_root[ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= p_rad;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_root = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

// ===== rtl/core/bnf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnf_div
// pipelined restoring divider, (smag << frac) / root, one quotient bit per stage
// ----------------------------------------------------------------------------
module bnf_div import bnf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [ROOT_BITS-1:0]    i_den,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic [QUO_BITS-1:0]     o_quo,
    output logic [DIV_REM_BITS-1:0] o_rem,
    output logic [ROOT_BITS-1:0]    o_den,
    output t_side                   o_side
);

    logic                    r_vld  [NUM_BITS];
    logic [DIV_REM_BITS-1:0] r_rem  [NUM_BITS];
    logic [QUO_BITS-1:0]     r_quo  [NUM_BITS];
    logic [ROOT_BITS-1:0]    r_den  [NUM_BITS];
    t_side                   r_side [NUM_BITS];

    genvar g;
    for (g = 0; g < NUM_BITS; g++) begin : g_stage
        logic                    p_vld;
        logic [DIV_REM_BITS-1:0] p_rem;
        logic [QUO_BITS-1:0]     p_quo;
        logic [ROOT_BITS-1:0]    p_den;
        t_side                   p_side;
        logic [NUM_BITS-1:0]     w_num;
        logic [DIV_REM_BITS-1:0] w_rem;
        logic [DIV_REM_BITS-1:0] n_rem;
        logic [QUO_BITS-1:0]     n_quo;

        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_quo  = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_quo  = r_quo[g-1];
            assign p_den  = r_den[g-1];
            assign p_side = r_side[g-1];
        end

        assign w_num = {p_side.smag, {FRAC_BITS{1'b0}}};
        assign w_rem = {p_rem[DIV_REM_BITS-2:0], w_num[NUM_BITS-1-g]};

        always_comb begin
            if (w_rem >= {1'b0, p_den}) begin
                n_rem = w_rem - {1'b0, p_den};
                n_quo = {p_quo[QUO_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_rem;
                n_quo = {p_quo[QUO_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
                r_den[g]  <= p_den;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[NUM_BITS-1];
    assign o_quo  = r_quo[NUM_BITS-1];
    assign o_rem  = r_rem[NUM_BITS-1];
    assign o_den  = r_den[NUM_BITS-1];
    assign o_side = r_side[NUM_BITS-1];

endmodule

// ===== rtl/core/batchnorm_fold_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batchnorm_fold_channel
// folds one batch-norm channel into a multiplier and an offset
// pipeline stages from input beat to output beat: 1 input, 24 root, 48 divide,
//   round, saturate, multiply, output; the root and divider each resolve one bit per stage
// throughput: one beat per cycle; the whole pipeline holds while the output stalls
// reset: synchronous active-low, clears valid bits and sets epsilon to 1
// ----------------------------------------------------------------------------
module batchnorm_fold_channel import bnf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [EPS_BITS-1:0]  i_cfg_wr_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // scale, bias, mean, variance, zero pad
    input  logic [TDATA_IN-1:0]  i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // folded_scale, folded_bias
    output logic [TDATA_OUT-1:0] o_m_axis_tdata,
    // saturated, invalid
    output logic [1:0]           o_m_axis_tuser
);

    localparam int QR_BITS = QUO_BITS + 1;
    localparam int DW      = PROD_BITS + 2;
    localparam logic [QR_BITS-1:0] LIM_NEG = QR_BITS'(1) << (WORD_BITS - 1);
    localparam logic [QR_BITS-1:0] LIM_POS = LIM_NEG - QR_BITS'(1);
    localparam logic [PROD_BITS:0] HALF_LSB = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [DW-1:0] FB_MAX =
        {{(DW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [DW-1:0] FB_MIN =
        {{(DW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

    logic                  en;
    logic [EPS_BITS-1:0]   r_eps;

    // input stage
    logic [WORD_BITS-1:0]  in_scale, in_bias, in_mean;
    logic [VAR_BITS-1:0]   in_var;
    logic [SUM_BITS-1:0]   in_sum;
    t_side                 n_side_in;
    logic                  r_vld_in;
    logic [RAD_PAD-1:0]    r_rad_in;
    t_side                 r_side_in;

    // root and divider
    logic                    sq_vld;
    logic [ROOT_BITS-1:0]    sq_root;
    t_side                   sq_side;
    logic                    dv_vld;
    logic [QUO_BITS-1:0]     dv_quo;
    logic [DIV_REM_BITS-1:0] dv_rem;
    logic [ROOT_BITS-1:0]    dv_den;
    t_side                   dv_side;

    // round, saturate, multiply, output
    logic                  r_vld_rd;
    logic [QR_BITS-1:0]    r_quo_rd;
    t_side                 r_side_rd;
    logic [QR_BITS-1:0]    lim;
    logic                  n_sat_fs;
    logic                  r_vld_st;
    logic [MAG_BITS-1:0]   r_fmag;
    logic                  r_sat_fs;
    t_side                 r_side_st;
    logic                  r_vld_mu;
    logic [PROD_BITS-1:0]  r_prod;
    logic [WORD_BITS-1:0]  r_fs_mu;
    logic                  r_sat_mu;
    t_side                 r_side_mu;
    logic [PROD_BITS:0]    prod_rnd;
    logic [DW-1:0]         pmag;
    logic signed [DW-1:0]  bias_x;
    logic signed [DW-1:0]  diff;
    logic [WORD_BITS-1:0]  n_fb;
    logic                  n_sat;
    logic                  r_out_vld;
    logic [WORD_BITS-1:0]  r_fs_out;
    logic [WORD_BITS-1:0]  r_fb_out;
    logic                  r_sat_out;
    logic                  r_inv_out;

    assign en              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_eps <= i_cfg_wr_data;
        end
    end

    assign in_scale = i_s_axis_tdata[WORD_BITS-1:0];
    assign in_bias  = i_s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
    assign in_mean  = i_s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];
    assign in_var   = i_s_axis_tdata[3*WORD_BITS+VAR_BITS-1:3*WORD_BITS];
    assign in_sum   = SUM_BITS'(in_var) + SUM_BITS'(r_eps);

    always_comb begin
        n_side_in.scale_neg = in_scale[WORD_BITS-1];
        n_side_in.smag      = in_scale[WORD_BITS-1] ? MAG_BITS'(-in_scale)
                                                    : MAG_BITS'(in_scale);
        n_side_in.bias      = in_bias;
        n_side_in.mean_neg  = in_mean[WORD_BITS-1];
        n_side_in.mmag      = in_mean[WORD_BITS-1] ? MAG_BITS'(-in_mean)
                                                   : MAG_BITS'(in_mean);
        n_side_in.invalid   = (in_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
        end else if (en) begin
            r_vld_in <= i_s_axis_tvalid;
        end
        if (en) begin
            r_rad_in  <= RAD_PAD'({in_sum, {FRAC_BITS{1'b0}}});
            r_side_in <= n_side_in;
        end
    end

    bnf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld_in),
        .i_rad   (r_rad_in),
        .i_side  (r_side_in),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    bnf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_den   (sq_root),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_rem   (dv_rem),
        .o_den   (dv_den),
        .o_side  (dv_side)
    );

    // round to nearest, ties away from zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_rd <= 1'b0;
        end else if (en) begin
            r_vld_rd <= dv_vld;
        end
        if (en) begin
            r_quo_rd  <= QR_BITS'(dv_quo) +
                         QR_BITS'({dv_rem, 1'b0} >= {2'b00, dv_den});
            r_side_rd <= dv_side;
        end
    end

    assign lim      = r_side_rd.scale_neg ? LIM_NEG : LIM_POS;
    assign n_sat_fs = r_quo_rd > lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_st <= 1'b0;
        end else if (en) begin
            r_vld_st <= r_vld_rd;
        end
        if (en) begin
            r_fmag    <= n_sat_fs ? MAG_BITS'(lim) : MAG_BITS'(r_quo_rd);
            r_sat_fs  <= n_sat_fs;
            r_side_st <= r_side_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_mu <= 1'b0;
        end else if (en) begin
            r_vld_mu <= r_vld_st;
        end
        if (en) begin
            r_prod    <= PROD_BITS'(r_fmag) * PROD_BITS'(r_side_st.mmag);
            r_fs_mu   <= r_side_st.scale_neg ? WORD_BITS'(-r_fmag) : WORD_BITS'(r_fmag);
            r_sat_mu  <= r_sat_fs;
            r_side_mu <= r_side_st;
        end
    end

    assign prod_rnd = {1'b0, r_prod} + HALF_LSB;
    assign pmag     = DW'(prod_rnd[PROD_BITS:FRAC_BITS]);
    assign bias_x   = DW'($signed(r_side_mu.bias));
    assign diff     = (r_side_mu.scale_neg ^ r_side_mu.mean_neg)
                    ? bias_x + $signed(pmag) : bias_x - $signed(pmag);

    always_comb begin
        n_sat = r_sat_mu;
        if (diff > FB_MAX) begin
            n_fb  = WORD_BITS'(FB_MAX);
            n_sat = 1'b1;
        end else if (diff < FB_MIN) begin
            n_fb  = WORD_BITS'(FB_MIN);
            n_sat = 1'b1;
        end else begin
            n_fb  = WORD_BITS'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld_mu;
        end
        if (en) begin
            r_fs_out  <= r_side_mu.invalid ? '0 : r_fs_mu;
            r_fb_out  <= r_side_mu.invalid ? '0 : n_fb;
            r_sat_out <= r_side_mu.invalid ? 1'b0 : n_sat;
            r_inv_out <= r_side_mu.invalid;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_fb_out, r_fs_out};
    assign o_m_axis_tuser  = {r_inv_out, r_sat_out};

endmodule
